// ===== hdl/dnsq_pkg.sv =====
package dnsq_pkg;

    localparam int PACKET_BYTES_DEF = 1024;
    localparam int MAX_LABEL_DEF    = 63;

    localparam int HDR_BYTES  = 12;
    localparam int MAX_BEATS  = 12;
    localparam int END_BYTES  = 5;
    localparam int OFS_W      = 10;
    localparam int CNT_W      = 6;
    localparam int LEFT_W     = 4;

    localparam logic [7:0] DOT_CHAR  = 8'd46;
    localparam logic [7:0] CLASS_HI  = 8'h00;
    localparam logic [7:0] CLASS_LO  = 8'h01;

    // header bytes after the id: flags, qdcount, ancount, nscount, arcount
    localparam logic [7:0] HDR_TAIL [HDR_BYTES-2] = '{
        8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_CHAR  = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0]       data;
        logic [OFS_W-1:0] offset;
    } t_entry;

endpackage

// ===== hdl/dns_query_packet_builder_unit.sv =====
// the first output beat is valid in the cycle after the input beat is accepted
// throughput: one input beat per cycle for name characters while the receiver is ready;
// an item that yields n bytes holds the input until its last byte is taken (start 12, end up to 6)
// the output buffer drains one byte per cycle while the receiver is ready and refills on its last beat
// reset (synchronous, active low) clears positions, label state, overflow and id
module dns_query_packet_builder_unit #(
    parameter int PACKET_BYTES = dnsq_pkg::PACKET_BYTES_DEF,
    parameter int MAX_LABEL    = dnsq_pkg::MAX_LABEL_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // character[7:0], query_type[23:8]
    input  logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // out_byte[7:0], byte_offset[17:8], zero[23:18]
    output logic        o_m_axis_tlast,   // last
    output logic [0:0]  o_m_axis_tuser    // overflow[0]
);

    localparam int PW = $clog2(PACKET_BYTES + 1);
    localparam int OW = dnsq_pkg::OFS_W;
    localparam int NB = dnsq_pkg::MAX_BEATS;
    localparam int LW = dnsq_pkg::LEFT_W;
    localparam int CW = dnsq_pkg::CNT_W;
    localparam int EB = dnsq_pkg::END_BYTES;
    localparam logic [PW:0]   PB_X  = (PW+1)'(PACKET_BYTES);
    localparam logic [CW-1:0] MAX_L = CW'(MAX_LABEL);

    logic [15:0]    r_qid;
    logic [PW-1:0]  r_next_pos, n_next_pos;
    logic [PW-1:0]  r_label_start, n_label_start;
    logic [CW-1:0]  r_label_cnt, n_label_cnt;
    logic           r_ovf, n_ovf;
    logic           r_ovf_out;
    logic [LW-1:0]  r_left, n_left;
    dnsq_pkg::t_entry r_ent [NB];
    dnsq_pkg::t_entry n_ent [NB];

    logic           in_beat;
    logic           out_beat;
    logic [7:0]     in_char;
    logic [15:0]    in_qtype;
    logic [1:0]     in_kind;

    dnsq_pkg::t_entry cand [EB+1];
    logic [EB:0]      cand_v;
    logic [PW-1:0]    end_base;
    logic [PW:0]      end_sum [EB+1];

    function automatic logic [OW-1:0] ofs(input logic [PW-1:0] p);
        logic [OW+PW-1:0] t;
        t = {{OW{1'b0}}, p};
        return t[OW-1:0];
    endfunction

    function automatic logic lt_pb(input logic [PW-1:0] p);
        return {1'b0, p} < PB_X;
    endfunction

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
        return lt_pb(p) ? p + PW'(1) : PB_X[PW-1:0];
    endfunction

    assign in_char  = i_s_axis_tdata[7:0];
    assign in_qtype = i_s_axis_tdata[23:8];
    assign in_kind  = i_s_axis_tuser;

    assign o_s_axis_tready = (r_left == '0) || (r_left == LW'(1) && i_m_axis_tready);
    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_beat = o_m_axis_tvalid && i_m_axis_tready;

    assign o_m_axis_tvalid = (r_left != '0);
    assign o_m_axis_tdata  = {6'd0, r_ent[0].offset, r_ent[0].data};
    assign o_m_axis_tlast  = (r_left == LW'(1));
    assign o_m_axis_tuser  = r_ovf_out;

    // end of name candidates: pending label length, then five trailer bytes
    always_comb begin
        end_base = (r_label_cnt != '0) ? r_next_pos : r_label_start;
        cand[0].data   = {2'b00, r_label_cnt};
        cand[0].offset = ofs(r_label_start);
        cand_v[0]      = (r_label_cnt != '0) && lt_pb(r_label_start);
        for (int i = 0; i <= EB; i++) begin
            end_sum[i] = {1'b0, end_base} + (PW+1)'(i);
        end
        for (int i = 0; i < EB; i++) begin
            cand[i+1].offset = ofs(end_sum[i][PW-1:0]);
            cand_v[i+1]      = end_sum[i] < PB_X;
        end
        cand[1].data = 8'h00;
        cand[2].data = in_qtype[15:8];
        cand[3].data = in_qtype[7:0];
        cand[4].data = dnsq_pkg::CLASS_HI;
        cand[5].data = dnsq_pkg::CLASS_LO;
    end

    always_comb begin
        n_next_pos    = r_next_pos;
        n_label_start = r_label_start;
        n_label_cnt   = r_label_cnt;
        n_ovf         = r_ovf;
        n_left        = r_left;
        for (int i = 0; i < NB; i++) begin
            n_ent[i] = (out_beat && i < NB - 1) ? r_ent[(i + 1) % NB] : r_ent[i];
        end
        if (out_beat) begin
            n_left = r_left - LW'(1);
        end
        if (in_beat) begin
            n_left = '0;
            unique case (in_kind)
                dnsq_pkg::KIND_START: begin
                    n_ovf = 1'b0;
                    n_ent[0].data = r_qid[15:8];
                    n_ent[1].data = r_qid[7:0];
                    for (int i = 2; i < NB; i++) begin
                        n_ent[i].data = dnsq_pkg::HDR_TAIL[i-2];
                    end
                    for (int i = 0; i < NB; i++) begin
                        n_ent[i].offset = OW'(i);
                    end
                    n_left        = LW'(NB);
                    n_label_start = PW'(dnsq_pkg::HDR_BYTES);
                    n_next_pos    = PW'(dnsq_pkg::HDR_BYTES + 1);
                    n_label_cnt   = '0;
                end
                dnsq_pkg::KIND_CHAR: begin
                    if (in_char == dnsq_pkg::DOT_CHAR) begin
                        n_ent[0].data   = {2'b00, r_label_cnt};
                        n_ent[0].offset = ofs(r_label_start);
                        if (lt_pb(r_label_start)) begin
                            n_left = LW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_label_start = r_next_pos;
                        n_next_pos    = adv(r_next_pos);
                        n_label_cnt   = '0;
                    end else if (r_label_cnt >= MAX_L) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_ent[0].data   = in_char;
                        n_ent[0].offset = ofs(r_next_pos);
                        if (lt_pb(r_next_pos)) begin
                            n_left = LW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_next_pos  = adv(r_next_pos);
                        n_label_cnt = r_label_cnt + CW'(1);
                    end
                end
                dnsq_pkg::KIND_END: begin
                    for (int i = 0; i <= EB; i++) begin
                        if (cand_v[0]) begin
                            n_ent[i] = cand[i];
                        end else if (i < EB) begin
                            n_ent[i] = cand[i+1];
                        end
                    end
                    n_left = LW'(cand_v[0]) + LW'($countones(cand_v[EB:1]));
                    if (!(&cand_v[EB:1]) || (r_label_cnt != '0 && !cand_v[0])) begin
                        n_ovf = 1'b1;
                    end
                    n_label_start = end_sum[EB] < PB_X ? end_sum[EB][PW-1:0]
                                                       : PB_X[PW-1:0];
                    n_next_pos    = adv(n_label_start);
                    n_label_cnt   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qid         <= '0;
            r_next_pos    <= '0;
            r_label_start <= '0;
            r_label_cnt   <= '0;
            r_ovf         <= 1'b0;
            r_left        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_qid <= i_cfg_wdata;
            end
            r_next_pos    <= n_next_pos;
            r_label_start <= n_label_start;
            r_label_cnt   <= n_label_cnt;
            r_ovf         <= n_ovf;
            r_left        <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_ovf_out <= n_ovf;
        end
        for (int i = 0; i < NB; i++) begin
            r_ent[i] <= n_ent[i];
        end
    end

`ifndef ASSERT_OFF
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= LW'(NB))
        else $error("output beat count out of range");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_next_pos} <= PB_X) && ({1'b0, r_label_start} <= PB_X))
        else $error("position past packet size");

    a_label_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_label_cnt <= MAX_L)
        else $error("label count past limit");

    a_start_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && in_kind == dnsq_pkg::KIND_START) |=>
        (r_left == LW'(NB) && r_ent[0].offset == '0 && r_ovf_out == 1'b0))
        else $error("start did not load the header");

    a_flag_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && !o_m_axis_tlast) |=> (o_m_axis_tuser == $past(o_m_axis_tuser)))
        else $error("overflow flag changed within one item");
`endif

endmodule

// ===== tb/sv/dnsq_checker.sv =====
module dnsq_checker #(
    parameter int PACKET_BYTES = dnsq_pkg::PACKET_BYTES_DEF,
    parameter int MAX_LABEL    = dnsq_pkg::MAX_LABEL_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // character[7:0], query_type[23:8]
    input  logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [23:0] i_m_axis_tdata,   // out_byte[7:0], byte_offset[17:8], zero[23:18]
    input  logic        i_m_axis_tlast,   // last
    input  logic [0:0]  i_m_axis_tuser,   // overflow[0]
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] LABEL_SEP = 8'h2e;

    typedef struct packed {
        logic [7:0]                 data;
        logic [dnsq_pkg::OFS_W-1:0] offset;
        logic                       last;
        logic                       ovf;
    } t_dns_byte;

    logic [15:0]                id_reg;
    logic [10:0]                wr_pos;
    logic [10:0]                slot_pos;
    logic [dnsq_pkg::CNT_W-1:0] lbl_len;
    logic                       ovf_flag;
    t_dns_byte                  pkt_q[$];
    t_dns_byte                  item_bytes[$];
    int                         fails   = 0;
    int                         checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic logic [10:0] step_pos(logic [10:0] p);
        return (p < PACKET_BYTES) ? p + 11'd1 : 11'(PACKET_BYTES);
    endfunction

    function automatic void emit_at(logic [10:0] pos, logic [7:0] val);
        t_dns_byte b;
        if (pos >= PACKET_BYTES) begin
            ovf_flag = 1'b1;
        end else begin
            b.data   = val;
            b.offset = pos[dnsq_pkg::OFS_W-1:0];
            b.last   = 1'b0;
            b.ovf    = 1'b0;
            item_bytes.push_back(b);
        end
    endfunction

    function automatic void emit_next(logic [7:0] val);
        emit_at(wr_pos, val);
        wr_pos = step_pos(wr_pos);
    endfunction

    function automatic void build_bytes(dnsq_pkg::t_kind kind, logic [7:0] ch,
                                        logic [15:0] qt);
        item_bytes.delete();
        case (kind)
            dnsq_pkg::KIND_START: begin
                ovf_flag = 1'b0;
                emit_at(11'd0, id_reg[15:8]);
                emit_at(11'd1, id_reg[7:0]);
                emit_at(11'd2, 8'h01);
                emit_at(11'd3, 8'h00);
                emit_at(11'd4, 8'h00);
                emit_at(11'd5, 8'h01);
                for (int i = 6; i < 12; i++) begin
                    emit_at(11'(i), 8'h00);
                end
                slot_pos = 11'd12;
                wr_pos   = step_pos(11'd12);
                lbl_len  = '0;
            end
            dnsq_pkg::KIND_CHAR: begin
                if (ch == LABEL_SEP) begin
                    emit_at(slot_pos, 8'(lbl_len));
                    slot_pos = wr_pos;
                    wr_pos   = step_pos(wr_pos);
                    lbl_len  = '0;
                end else if (lbl_len >= MAX_LABEL) begin
                    ovf_flag = 1'b1;
                end else begin
                    emit_next(ch);
                    lbl_len = lbl_len + 1'b1;
                end
            end
            dnsq_pkg::KIND_END: begin
                if (lbl_len != 0) begin
                    emit_at(slot_pos, 8'(lbl_len));
                end else begin
                    wr_pos = slot_pos;
                end
                emit_next(8'h00);
                emit_next(qt[15:8]);
                emit_next(qt[7:0]);
                emit_next(8'h00);
                emit_next(8'h01);
                slot_pos = wr_pos;
                wr_pos   = step_pos(wr_pos);
                lbl_len  = '0;
            end
            default: ;
        endcase
        for (int k = 0; k < item_bytes.size(); k++) begin
            item_bytes[k].last = (k == item_bytes.size() - 1);
            item_bytes[k].ovf  = ovf_flag;
            pkt_q.push_back(item_bytes[k]);
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
        fails++;
        $display("%0t: %s mismatch, expected %h actual %h", $realtime, what, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : watch
        t_dns_byte want;
        if (!i_rst_n) begin
            id_reg   = '0;
            wr_pos   = '0;
            slot_pos = '0;
            lbl_len  = '0;
            ovf_flag = 1'b0;
            pkt_q.delete();
        end else begin
            if (i_cfg_we) begin
                id_reg = i_cfg_wdata;
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (pkt_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected output beat, expected none actual %h",
                             $realtime, i_m_axis_tdata);
                end else begin
                    want = pkt_q.pop_front();
                    checked++;
                    if (i_m_axis_tdata[7:0] !== want.data)
                        flag_mismatch("out_byte", 16'(want.data), 16'(i_m_axis_tdata[7:0]));
                    if (i_m_axis_tdata[17:8] !== want.offset)
                        flag_mismatch("byte_offset", 16'(want.offset),
                                      16'(i_m_axis_tdata[17:8]));
                    if (i_m_axis_tdata[23:18] !== 6'd0)
                        flag_mismatch("tdata padding", 16'd0, 16'(i_m_axis_tdata[23:18]));
                    if (i_m_axis_tlast !== want.last)
                        flag_mismatch("last", 16'(want.last), 16'(i_m_axis_tlast));
                    if (i_m_axis_tuser[0] !== want.ovf)
                        flag_mismatch("overflow", 16'(want.ovf), 16'(i_m_axis_tuser[0]));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                build_bytes(dnsq_pkg::t_kind'(i_s_axis_tuser), i_s_axis_tdata[7:0],
                            i_s_axis_tdata[23:8]);
            end
        end
        o_pending    <= pkt_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         PKT_BYTES     = dnsq_pkg::PACKET_BYTES_DEF;
    localparam int         LABEL_MAX     = dnsq_pkg::MAX_LABEL_DEF;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         FILL_ENDS     = 203;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    int fail_count;
    int pending;
    int checked;

    int   n_items    = 0;
    int   n_ids      = 0;
    int   stuck      = 0;
    int   hold_left  = 0;
    int   stall_left = 0;
    int   hold_req   = 0;
    int   hold_seen  = 0;
    logic quiet      = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    dns_query_packet_builder_unit #(
        .PACKET_BYTES (PKT_BYTES),
        .MAX_LABEL    (LABEL_MAX)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    dnsq_checker #(
        .PACKET_BYTES (PKT_BYTES),
        .MAX_LABEL    (LABEL_MAX)
    ) u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tlast  (m_tlast),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // receiver: random stalls, one long hold on request, always ready when quiet
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
        if (stuck >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $realtime, stuck);
            $display("** dns_query_packet_builder_unit: FAILED **");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [15:0] qt);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {qt, ch};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        if (kind != KIND_UNUSED) n_items++;
    endtask

    task automatic send_start();
        send_item(dnsq_pkg::KIND_START, 8'($urandom), 16'($urandom));
    endtask

    task automatic send_dot();
        send_item(dnsq_pkg::KIND_CHAR, dnsq_pkg::DOT_CHAR, 16'($urandom));
    endtask

    task automatic send_end(input logic [15:0] qt);
        send_item(dnsq_pkg::KIND_END, 8'($urandom), qt);
    endtask

    task automatic send_label(input int len);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            c = 8'($urandom);
            if (c == dnsq_pkg::DOT_CHAR) c = c + 8'd1;
            send_item(dnsq_pkg::KIND_CHAR, c, 16'($urandom));
        end
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
    endtask

    // mostly well-formed queries with random content, some broken or noisy
    task automatic send_query();
        int labels;
        labels = $urandom_range(0, 4);
        if ($urandom_range(0, 9) != 0) send_start();
        for (int l = 0; l < labels; l++) begin
            if ($urandom_range(0, 24) == 0) send_label($urandom_range(64, 70));
            else send_label($urandom_range(0, 12));
            if (l < labels - 1 || $urandom_range(0, 3) == 0) send_dot();
            if ($urandom_range(0, 15) == 0) send_noise();
        end
        if ($urandom_range(0, 11) != 0) send_end(16'($urandom));
    endtask

    task automatic run_queries(input int count, input logic pressure);
        int stop_at;
        int hold_at;
        stop_at = n_items + count;
        hold_at = n_items + count / 3;
        while (n_items < stop_at) begin
            if (pressure && n_items >= hold_at) begin
                hold_req++;
                pressure = 1'b0;
            end
            send_query();
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_id(input logic [15:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_ids++;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_id(16'hffff);

        // characters and an end before any start, then an unused kind
        send_item(dnsq_pkg::KIND_CHAR, 8'h78, 16'h0000);
        send_end(16'h0001);
        send_item(KIND_UNUSED, 8'hff, 16'hffff);
        // extreme characters, an empty label, items after end
        send_item(dnsq_pkg::KIND_START, 8'h00, 16'h0000);
        send_item(dnsq_pkg::KIND_CHAR, 8'h00, 16'hffff);
        send_item(dnsq_pkg::KIND_CHAR, 8'hff, 16'h0000);
        send_item(dnsq_pkg::KIND_CHAR, 8'h77, 16'h1234);
        send_dot();
        send_dot();
        send_item(dnsq_pkg::KIND_CHAR, 8'h63, 16'h0000);
        send_end(16'hffff);
        send_item(dnsq_pkg::KIND_CHAR, 8'h7a, 16'h0000);
        send_end(16'h0000);
        // trailing dot, then an empty name
        send_start();
        send_dot();
        send_end(16'h0001);
        send_start();
        send_end(16'h001c);
        settle();

        // fill the buffer with empty names until a trailer crosses its end
        write_id(16'h0000);
        send_start();
        for (int e = 0; e < FILL_ENDS; e++) begin
            send_end(16'($urandom));
        end
        send_label(4);
        send_dot();
        send_end(16'h001c);
        // one oversize label
        send_start();
        send_label(66);
        send_end(16'h0001);
        settle();

        write_id(16'($urandom));
        run_queries(35, 1'b1);
        settle();

        write_id(16'($urandom));
        run_queries(25, 1'b0);
        settle();

        write_id(16'h8001);
        quiet = 1'b1;
        run_queries(15, 1'b0);
        settle();

        if (pending != 0) begin
            $display("%0t: %0d expected bytes never arrived", $realtime, pending);
        end
        $display("run covered %0d input items and %0d checked output bytes over %0d id values,",
                 n_items, checked, n_ids);
        $display("including a buffer fill past its end, oversize labels and a long output hold");
        if (fail_count == 0 && pending == 0) begin
            $display("** dns_query_packet_builder_unit: PASSED **");
        end else begin
            $display("** dns_query_packet_builder_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dnsq_pkg.sv
hdl/dns_query_packet_builder_unit.sv
tb/sv/dnsq_checker.sv
tb/sv/tb.sv
